// File: rtl/xsa_pkg.sv
// shared types and constants for the xyz sample averager
`timescale 1ns / 1ps
`default_nettype none

package xsa_pkg;

    localparam int SUM_W   = 16;
    localparam int COUNT_W = 8;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam int DATA_READY_BIT = 3;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_GET    = 1'b1;

    localparam logic [0:0] REG_AVERAGE_COUNT = 1'b0;
    localparam logic [COUNT_W-1:0] AVERAGE_COUNT_RESET = 8'd16;

    typedef struct packed {
        logic [SUM_W-1:0]   x_sum;
        logic [SUM_W-1:0]   y_sum;
        logic [SUM_W-1:0]   z_sum;
        logic [COUNT_W-1:0] count;
    } t_entry;

    typedef struct packed {
        logic push;
        logic pop;
    } t_ring_ctl;

    typedef struct packed {
        logic empty;
        logic full;
    } t_ring_status;

endpackage

`default_nettype wire

// File: rtl/xsa_ring.sv
// ring buffer of completed window entries with registered read
`timescale 1ns / 1ps
`default_nettype none

module xsa_ring #(
    parameter int RING_SLOTS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  xsa_pkg::t_ring_ctl         i_ctl,
    input  xsa_pkg::t_entry            i_wr_entry,
    output xsa_pkg::t_ring_status      o_status,
    output xsa_pkg::t_entry            o_rd_entry
);
    import xsa_pkg::*;

    localparam int PTR_W = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(RING_SLOTS - 1);

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        if (p == LAST_SLOT) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    t_entry           r_mem [RING_SLOTS];
    t_entry           r_rd_entry;
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            if (i_ctl.push) begin
                r_wr_ptr <= next_slot(r_wr_ptr);
            end
            if (i_ctl.pop) begin
                r_rd_ptr <= next_slot(r_rd_ptr);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_mem[r_wr_ptr] <= i_wr_entry;
        end
        if (i_ctl.pop) begin
            r_rd_entry <= r_mem[r_rd_ptr];
        end
    end

    assign o_status.empty = (r_wr_ptr == r_rd_ptr);
    assign o_status.full  = (next_slot(r_wr_ptr) == r_rd_ptr);
    assign o_rd_entry     = r_rd_entry;

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.push |-> !o_status.full)
        else $error("push into full ring");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.pop |-> !o_status.empty)
        else $error("pop from empty ring");

    a_push_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.push && !i_ctl.pop) |=> !o_status.empty)
        else $error("ring empty after push");

endmodule

`default_nettype wire

// File: rtl/xyz_sample_averager_fifo.sv
// xyz sample averager: accumulate-and-dump windows into a result ring
//
// input channel (i_valid / o_ready) carries requests: command 0 is a sensor
// sample, command 1 asks for the oldest completed window
// samples with status bit 3 set are summed; when the count reaches
// average_count the sums and count go into the ring and the window clears
// a full ring drops the window and sets a sticky overflow flag
// output channel (o_valid / i_ready) returns one result per get request,
// in the cycle after the request is accepted; samples return nothing
// throughput is one request per cycle while o_ready is high, set by the
// single add and compare pass between input handshake and result register
// when the receiver stalls the result is held and o_ready drops until it
// is taken; a new request is taken in the same cycle the result leaves
// reset clears accumulators, ring pointers and the overflow flag and sets
// average_count to 16; ring contents need no clearing
// average_count sits at apb byte address 0, pready is always high
`timescale 1ns / 1ps
`default_nettype none

module xyz_sample_averager_fifo #(
    parameter int RING_SLOTS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,

    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [xsa_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [xsa_pkg::PDATA_W-1:0]   pwdata,
    output logic      [xsa_pkg::PDATA_W-1:0]   prdata,
    output logic                               pready,

    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic                          i_command,
    input  wire logic [7:0]                    i_status_byte,
    input  wire logic signed [7:0]             i_x_sample,
    input  wire logic signed [7:0]             i_y_sample,
    input  wire logic signed [7:0]             i_z_sample,

    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic                               o_entry_valid,
    output logic signed [15:0]                 o_x_sum,
    output logic signed [15:0]                 o_y_sum,
    output logic signed [15:0]                 o_z_sum,
    output logic [7:0]                         o_sample_count,
    output logic                               o_overflow_seen
);
    import xsa_pkg::*;

    logic [COUNT_W-1:0] r_avg_count;
    logic [SUM_W-1:0]   r_x_acc;
    logic [SUM_W-1:0]   r_y_acc;
    logic [SUM_W-1:0]   r_z_acc;
    logic [COUNT_W-1:0] r_win_count;
    logic               r_overflow;
    logic               r_out_valid;
    logic               r_out_hit;
    logic               r_out_ovf;

    logic [SUM_W-1:0]   n_x_acc;
    logic [SUM_W-1:0]   n_y_acc;
    logic [SUM_W-1:0]   n_z_acc;
    logic [COUNT_W-1:0] n_win_count;

    logic               in_acc;
    logic               get_acc;
    logic               sample_acc;
    logic               window_done;
    logic               cfg_wr;

    t_ring_ctl          ring_ctl;
    t_ring_status       ring_status;
    t_entry             wr_entry;
    t_entry             rd_entry;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready
                     && (paddr[2] == REG_AVERAGE_COUNT);
    assign prdata  = (paddr[2] == REG_AVERAGE_COUNT)
                     ? {{(PDATA_W-COUNT_W){1'b0}}, r_avg_count} : '0;

    assign o_ready    = !r_out_valid || i_ready;
    assign in_acc     = i_valid && o_ready;
    assign get_acc    = in_acc && (i_command == CMD_GET);
    assign sample_acc = in_acc && (i_command == CMD_SAMPLE)
                        && i_status_byte[DATA_READY_BIT];

    always_comb begin
        n_x_acc     = r_x_acc + {{(SUM_W-8){i_x_sample[7]}}, i_x_sample};
        n_y_acc     = r_y_acc + {{(SUM_W-8){i_y_sample[7]}}, i_y_sample};
        n_z_acc     = r_z_acc + {{(SUM_W-8){i_z_sample[7]}}, i_z_sample};
        n_win_count = r_win_count + 1'b1;
        window_done = (n_win_count >= r_avg_count);
    end

    assign wr_entry.x_sum = n_x_acc;
    assign wr_entry.y_sum = n_y_acc;
    assign wr_entry.z_sum = n_z_acc;
    assign wr_entry.count = n_win_count;

    assign ring_ctl.push = sample_acc && window_done && !ring_status.full;
    assign ring_ctl.pop  = get_acc && !ring_status.empty;

    xsa_ring #(
        .RING_SLOTS (RING_SLOTS)
    ) u_ring (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ring_ctl),
        .i_wr_entry (wr_entry),
        .o_status   (ring_status),
        .o_rd_entry (rd_entry)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg_count <= AVERAGE_COUNT_RESET;
            r_x_acc     <= '0;
            r_y_acc     <= '0;
            r_z_acc     <= '0;
            r_win_count <= '0;
            r_overflow  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_wr) begin
                r_avg_count <= pwdata[COUNT_W-1:0];
            end
            if (sample_acc) begin
                if (window_done) begin
                    r_x_acc     <= '0;
                    r_y_acc     <= '0;
                    r_z_acc     <= '0;
                    r_win_count <= '0;
                    if (ring_status.full) begin
                        r_overflow <= 1'b1;
                    end
                end else begin
                    r_x_acc     <= n_x_acc;
                    r_y_acc     <= n_y_acc;
                    r_z_acc     <= n_z_acc;
                    r_win_count <= n_win_count;
                end
            end
            if (get_acc) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (get_acc) begin
            r_out_hit <= !ring_status.empty;
            r_out_ovf <= r_overflow;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_entry_valid   = r_out_hit;
    assign o_x_sum         = r_out_hit ? $signed(rd_entry.x_sum) : '0;
    assign o_y_sum         = r_out_hit ? $signed(rd_entry.y_sum) : '0;
    assign o_z_sum         = r_out_hit ? $signed(rd_entry.z_sum) : '0;
    assign o_sample_count  = r_out_hit ? rd_entry.count : '0;
    assign o_overflow_seen = r_out_ovf;

    a_get_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        get_acc |=> r_out_valid)
        else $error("get request without result");

    a_overflow_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_overflow) |-> r_overflow)
        else $error("overflow flag cleared");

    a_window_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (sample_acc && window_done) |=> (r_win_count == '0))
        else $error("window count not cleared after completion");

endmodule

`default_nettype wire

// File: sim/xyz_sample_averager_fifo_tb.sv
// self-checking testbench for the xyz sample averager with result ring
`timescale 1ns / 1ps

module xyz_sample_averager_fifo_tb;

    import xsa_pkg::*;

    localparam int RING_SLOTS       = 16;
    localparam int RESET_CYCLES     = 11;
    localparam int IDLE_LIMIT       = 2000;
    localparam int SETTLE_CYCLES    = 4;
    localparam int DRAIN_CYCLES     = 10;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int NUM_PHASES       = 14;
    localparam int WIDE_PHASE       = 2;
    localparam int HOLD_PHASE       = 5;
    localparam int OVERFLOW_PHASE   = 7;
    localparam int ZERO_AVG_PHASE   = 9;
    localparam int PHASE_ITEMS      = 120;
    localparam int WIDE_ITEMS       = 700;

    localparam logic [PADDR_W-1:0] AVG_ADDR   = PADDR_W'(4 * REG_AVERAGE_COUNT);
    localparam logic [7:0]         READY_MASK = 8'(1 << DATA_READY_BIT);

    typedef logic [$clog2(RING_SLOTS)-1:0] t_slot;

    typedef struct packed {
        logic              valid;
        logic [SUM_W-1:0]  x_sum;
        logic [SUM_W-1:0]  y_sum;
        logic [SUM_W-1:0]  z_sum;
        logic [COUNT_W-1:0] count;
        logic              ovf;
    } t_readout;

    typedef enum logic { ROW_REQUEST, ROW_CONFIG } t_row_kind;

    typedef struct packed {
        t_row_kind  kind;
        logic [7:0] cfg_val;
        logic       cmd;
        logic [7:0] status;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] z;
        logic       typed;
        t_readout   exp;
    } t_row;

    localparam t_readout NO_ENTRY  = '0;
    localparam t_readout TOP_ENTRY = '{1'b1, 16'h007f, 16'h007f, 16'h007f, 8'd1, 1'b0};
    localparam t_readout LOW_ENTRY = '{1'b1, 16'hff80, 16'hff80, 16'hff80, 8'd1, 1'b0};

    localparam int NUM_ROWS = 22;
    localparam t_row DIRECTED [NUM_ROWS] = '{
        '{ROW_REQUEST, 8'd0,   CMD_GET,    8'h00, 8'h00, 8'h00, 8'h00, 1'b1, NO_ENTRY},
        '{ROW_REQUEST, 8'd0,   CMD_SAMPLE, 8'hf7, 8'h7f, 8'h80, 8'hff, 1'b0, NO_ENTRY},
        '{ROW_REQUEST, 8'd0,   CMD_GET,    8'hff, 8'hff, 8'hff, 8'hff, 1'b1, NO_ENTRY},
        '{ROW_CONFIG,  8'd1,   CMD_SAMPLE, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, NO_ENTRY},
        '{ROW_REQUEST, 8'd0,   CMD_SAMPLE, 8'h08, 8'h7f, 8'h7f, 8'h7f, 1'b0, NO_ENTRY},
        '{ROW_REQUEST, 8'd0,   CMD_SAMPLE, 8'hff, 8'h80, 8'h80, 8'h80, 1'b0, NO_ENTRY},
        '{ROW_REQUEST, 8'd0,   CMD_GET,    8'h00, 8'h00, 8'h00, 8'h00, 1'b1, TOP_ENTRY},
        '{ROW_REQUEST, 8'd0,   CMD_GET,    8'h00, 8'h00, 8'h00, 8'h00, 1'b1, LOW_ENTRY},
        '{ROW_REQUEST, 8'd0,   CMD_GET,    8'h00, 8'h00, 8'h00, 8'h00, 1'b1, NO_ENTRY},
        '{ROW_CONFIG,  8'd2,   CMD_SAMPLE, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, NO_ENTRY},
        '{ROW_REQUEST, 8'd0,   CMD_SAMPLE, 8'h08, 8'h80, 8'h7f, 8'h00, 1'b0, NO_ENTRY},
        '{ROW_REQUEST, 8'd0,   CMD_SAMPLE, 8'h00, 8'h55, 8'h55, 8'h55, 1'b0, NO_ENTRY},
        '{ROW_REQUEST, 8'd0,   CMD_SAMPLE, 8'h0c, 8'h80, 8'h7f, 8'h01, 1'b0, NO_ENTRY},
        '{ROW_REQUEST, 8'd0,   CMD_GET,    8'h00, 8'h00, 8'h00, 8'h00, 1'b0, NO_ENTRY},
        '{ROW_CONFIG,  8'd255, CMD_SAMPLE, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, NO_ENTRY},
        '{ROW_REQUEST, 8'd0,   CMD_SAMPLE, 8'h08, 8'h7f, 8'h7f, 8'h80, 1'b0, NO_ENTRY},
        '{ROW_REQUEST, 8'd0,   CMD_SAMPLE, 8'hf8, 8'h01, 8'hfe, 8'h7f, 1'b0, NO_ENTRY},
        '{ROW_CONFIG,  8'd0,   CMD_SAMPLE, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, NO_ENTRY},
        '{ROW_REQUEST, 8'd0,   CMD_SAMPLE, 8'h08, 8'h01, 8'h02, 8'h03, 1'b0, NO_ENTRY},
        '{ROW_REQUEST, 8'd0,   CMD_GET,    8'h00, 8'h00, 8'h00, 8'h00, 1'b0, NO_ENTRY},
        '{ROW_REQUEST, 8'd0,   CMD_GET,    8'h00, 8'h00, 8'h00, 8'h00, 1'b1, NO_ENTRY},
        '{ROW_CONFIG,  8'd16,  CMD_SAMPLE, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, NO_ENTRY}
    };

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr   = '0;
    logic [PDATA_W-1:0] pwdata  = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    logic              i_valid       = 1'b0;
    logic              o_ready;
    logic              i_command     = CMD_SAMPLE;
    logic [7:0]        i_status_byte = '0;
    logic signed [7:0] i_x_sample    = '0;
    logic signed [7:0] i_y_sample    = '0;
    logic signed [7:0] i_z_sample    = '0;

    logic               o_valid;
    logic               i_ready = 1'b0;
    logic               o_entry_valid;
    logic signed [15:0] o_x_sum;
    logic signed [15:0] o_y_sum;
    logic signed [15:0] o_z_sum;
    logic [7:0]         o_sample_count;
    logic               o_overflow_seen;

    // predictor state
    logic [COUNT_W-1:0] avg_cnt = AVERAGE_COUNT_RESET;
    logic [SUM_W-1:0]   acc_x   = '0;
    logic [SUM_W-1:0]   acc_y   = '0;
    logic [SUM_W-1:0]   acc_z   = '0;
    logic [COUNT_W-1:0] win_cnt = '0;
    t_readout           ring [RING_SLOTS];
    t_slot              wr_ptr  = '0;
    t_slot              rd_ptr  = '0;
    logic               overflow_latched = 1'b0;

    t_readout readout_q [$];
    t_readout typed_entry;
    bit       typed_valid  = 1'b0;
    bit       tx_burst     = 1'b0;
    bit       hold_request = 1'b0;
    int       fail_count   = 0;
    int       idle_cycles  = 0;

    xyz_sample_averager_fifo #(.RING_SLOTS(RING_SLOTS)) u_top (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void check_field(string name, logic signed [31:0] want,
                                        logic signed [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    task automatic accumulate_or_pop(input logic cmd, input logic [7:0] st,
                                     input logic [7:0] x, input logic [7:0] y,
                                     input logic [7:0] z, output bit produced,
                                     output t_readout r);
        r = '0;
        produced = 1'b0;
        if (cmd == CMD_SAMPLE) begin
            if (st[DATA_READY_BIT]) begin
                acc_x   = acc_x + {{8{x[7]}}, x};
                acc_y   = acc_y + {{8{y[7]}}, y};
                acc_z   = acc_z + {{8{z[7]}}, z};
                win_cnt = win_cnt + 1'b1;
                if (win_cnt >= avg_cnt) begin
                    if (t_slot'(wr_ptr + 1'b1) == rd_ptr) begin
                        overflow_latched = 1'b1;
                    end else begin
                        ring[wr_ptr] = '{1'b1, acc_x, acc_y, acc_z, win_cnt, 1'b0};
                        wr_ptr = wr_ptr + 1'b1;
                    end
                    acc_x   = '0;
                    acc_y   = '0;
                    acc_z   = '0;
                    win_cnt = '0;
                end
            end
        end else begin
            produced = 1'b1;
            if (rd_ptr != wr_ptr) begin
                r = ring[rd_ptr];
                rd_ptr = rd_ptr + 1'b1;
            end
            r.ovf = overflow_latched;
        end
    endtask

    // compare readouts, then fold accepted requests into the predictor
    always @(posedge i_clk) begin
        t_readout got;
        t_readout want;
        t_readout predicted;
        bit       produced;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                got = '{o_entry_valid, o_x_sum, o_y_sum, o_z_sum, o_sample_count,
                        o_overflow_seen};
                if (readout_q.size() == 0) begin
                    $error("readout with no get request waiting");
                    fail_count++;
                end else begin
                    want = readout_q.pop_front();
                    check_field("entry_valid", want.valid, got.valid);
                    check_field("x_sum", $signed(want.x_sum), $signed(got.x_sum));
                    check_field("y_sum", $signed(want.y_sum), $signed(got.y_sum));
                    check_field("z_sum", $signed(want.z_sum), $signed(got.z_sum));
                    check_field("sample_count", want.count, got.count);
                    check_field("overflow_seen", want.ovf, got.ovf);
                end
            end
            if (psel && penable && pwrite && pready && paddr == AVG_ADDR) begin
                avg_cnt = pwdata[COUNT_W-1:0];
            end
            if (i_valid && o_ready) begin
                accumulate_or_pop(i_command, i_status_byte, i_x_sample, i_y_sample,
                                  i_z_sample, produced, predicted);
                if (produced) readout_q.push_back(typed_valid ? typed_entry : predicted);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready) || (psel && penable)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // readout side: random stalls, quiet stretches, one long hold-off
    initial begin
        int unsigned stall;
        bit          burst;
        bit          held;
        stall = 0;
        burst = 1'b0;
        held  = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request && !held) begin
                held  = 1'b1;
                stall = LONG_HOLD_CYCLES;
            end
            if ($urandom_range(0, 149) == 0) burst = !burst;
            if (stall != 0) begin
                i_ready <= 1'b0;
                stall--;
            end else begin
                i_ready <= 1'b1;
                if (!burst && $urandom_range(0, 2) == 0) stall = pick_gap();
            end
        end
    end

    task automatic send_request(input logic cmd, input logic [7:0] st,
                                input logic [7:0] x, input logic [7:0] y,
                                input logic [7:0] z);
        int unsigned gap;
        i_valid       <= 1'b1;
        i_command     <= cmd;
        i_status_byte <= st;
        i_x_sample    <= x;
        i_y_sample    <= y;
        i_z_sample    <= z;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
        gap = tx_burst ? 0 : pick_gap();
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (readout_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // write then read back, back to back
    task automatic write_average_count(input logic [7:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= AVG_ADDR;
        pwdata  <= PDATA_W'(v);
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== PDATA_W'(v)) begin
            $error("average_count readback: expected %0d, got %0d", v, prdata);
            fail_count++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial begin
        int          items;
        int unsigned get_pct;
        logic [7:0]  avg;
        logic        cmd;
        logic [7:0]  st;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < NUM_ROWS; i++) begin
            if (DIRECTED[i].kind == ROW_CONFIG) begin
                wait_idle();
                write_average_count(DIRECTED[i].cfg_val);
            end else begin
                typed_valid = DIRECTED[i].typed;
                typed_entry = DIRECTED[i].exp;
                send_request(DIRECTED[i].cmd, DIRECTED[i].status, DIRECTED[i].x,
                             DIRECTED[i].y, DIRECTED[i].z);
            end
        end
        typed_valid = 1'b0;

        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_idle();
            if (p == OVERFLOW_PHASE) begin
                // fill the ring past capacity, then drain it and keep reading once it is empty
                write_average_count(8'd1);
                tx_burst = 1'b0;
                repeat (RING_SLOTS + 1) begin
                    send_request(CMD_SAMPLE, 8'($urandom) | READY_MASK, 8'($urandom),
                                 8'($urandom), 8'($urandom));
                end
                repeat (RING_SLOTS + 1) begin
                    send_request(CMD_GET, 8'($urandom), 8'($urandom), 8'($urandom),
                                 8'($urandom));
                end
            end else begin
                items   = PHASE_ITEMS;
                get_pct = $urandom_range(10, 45);
                if (p == WIDE_PHASE) begin
                    avg     = 8'd255;
                    items   = WIDE_ITEMS;
                    get_pct = 4;
                end else if (p == ZERO_AVG_PHASE) begin
                    avg = 8'd0;
                end else if ($urandom_range(0, 3) == 0) begin
                    avg = 8'($urandom_range(7, 40));
                end else begin
                    avg = 8'($urandom_range(1, 6));
                end
                write_average_count(avg);
                tx_burst = ($urandom_range(0, 3) == 0);
                if (p == HOLD_PHASE) begin
                    get_pct      = 40;
                    hold_request = 1'b1;
                end
                repeat (items) begin
                    cmd = ($urandom_range(0, 99) < get_pct) ? CMD_GET : CMD_SAMPLE;
                    st  = 8'($urandom);
                    if (cmd == CMD_SAMPLE) st[DATA_READY_BIT] = ($urandom_range(0, 99) < 85);
                    send_request(cmd, st, 8'($urandom), 8'($urandom), 8'($urandom));
                end
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
